// ----- rtl/quaternion_scale_to_model_matrix_unit_assert.svh -----
// assertion macros for the model matrix unit
`ifndef QUATERNION_SCALE_TO_MODEL_MATRIX_UNIT_ASSERT_SVH
`define QUATERNION_SCALE_TO_MODEL_MATRIX_UNIT_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define QSM_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define QSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/qsm_pkg.sv -----
`default_nettype none
package qsm_pkg;

    localparam int unsigned S_TDATA_W  = 320;
    localparam int unsigned M_TDATA_W  = 384;
    localparam int unsigned QBITS      = 31;
    localparam int unsigned PBITS      = 63;
    localparam int unsigned SBITS      = 33;
    localparam int unsigned MBITS      = 31;
    localparam int unsigned RBITS      = 32;
    localparam int unsigned VBITS      = 20;
    localparam int unsigned NTERMS     = 9;
    localparam int unsigned DIV_STAGES = 32;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QPTR       = $clog2(QDEPTH);

    localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
    // partial remainder of 2^61 before the 32 quotient bits
    localparam logic [MBITS-1:0]   DIV_SEED = 31'h2000_0000;
    localparam logic [NTERMS-1:0]  DIAG_MASK = 9'b100_010_001;

    typedef struct packed {
        logic [2:0][31:0] scale;
        logic [2:0][31:0] pos;
    } side_t;

    typedef struct packed {
        logic                         zero;
        logic [MBITS-1:0]             m;
        logic [NTERMS-1:0][SBITS-1:0] ps;
        side_t                        side;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage
`default_nettype wire

// ----- rtl/qsm_front.sv -----
`default_nettype none
module qsm_front (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire [3:0][31:0]  quat,
    input  wire [2:0][31:0]  scale,
    input  wire [2:0][31:0]  pos,
    input  wire              q_full,
    output logic             push,
    output qsm_pkg::work_t   push_data
);

    localparam logic signed [31:0] HALF_LIM = 32'sh4000_0000;
    localparam int unsigned QB = qsm_pkg::QBITS;
    localparam int unsigned PB = qsm_pkg::PBITS;

    function automatic logic [5:0] bit_len(input logic [PB-1:0] v);
        logic [5:0] b;
        b = '0;
        for (int i = 0; i < PB; i++) begin
            if (v[i]) begin
                b = 6'(i + 1);
            end
        end
        return b;
    endfunction

    logic                    fe;
    logic [4:0]              vld_reg;
    logic                    big;
    logic signed [QB-1:0]    q_next [4];
    qsm_pkg::side_t          side_next;
    logic signed [QB-1:0]    q_reg [4];
    qsm_pkg::side_t          side_reg [4];
    logic signed [2*QB-1:0]  sq_reg [4];
    logic signed [2*QB-1:0]  xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic [PB-1:0]           n_reg;
    logic signed [PB-1:0]    term_reg [qsm_pkg::NTERMS];
    logic [PB-1:0]           n_d_reg;
    logic signed [PB-1:0]    term_d_reg [qsm_pkg::NTERMS];
    logic signed [6:0]       d_reg;
    logic                    zero_reg;
    logic                    d_neg;
    logic [5:0]              amt;
    logic [PB-1:0]           m_wide;
    logic signed [PB-1:0]    p_sh [qsm_pkg::NTERMS];
    qsm_pkg::work_t          work_next;
    qsm_pkg::work_t          work_reg;

    assign fe        = !(vld_reg[4] && q_full);
    assign in_ready  = fe;
    assign push      = vld_reg[4] && !q_full;
    assign push_data = work_reg;

    // halve all components when one is too large, fix bad scales
    always_comb begin
        big = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if ($signed(quat[i]) >= HALF_LIM || $signed(quat[i]) <= -HALF_LIM) begin
                big = 1'b1;
            end
        end
        for (int i = 0; i < 4; i++) begin
            q_next[i] = big ? QB'($signed(quat[i]) >>> 1) : QB'($signed(quat[i]));
        end
        side_next.pos = pos;
        for (int i = 0; i < 3; i++) begin
            side_next.scale[i] = ($signed(scale[i]) <= 32'sd0) ? qsm_pkg::ONE_Q16 : scale[i];
        end
    end

    // normalizing shift of norm and terms
    always_comb begin
        d_neg  = d_reg[6];
        amt    = d_neg ? 6'(-d_reg) : d_reg[5:0];
        m_wide = d_neg ? (n_d_reg << amt) : (n_d_reg >> amt);
        for (int k = 0; k < qsm_pkg::NTERMS; k++) begin
            p_sh[k] = d_neg ? (term_d_reg[k] <<< amt) : (term_d_reg[k] >>> amt);
            work_next.ps[k] = p_sh[k][qsm_pkg::SBITS-1:0];
        end
        work_next.m    = m_wide[qsm_pkg::MBITS-1:0];
        work_next.zero = zero_reg;
        work_next.side = side_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (fe) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (fe) begin
            for (int i = 0; i < 4; i++) begin
                q_reg[i]  <= q_next[i];
                sq_reg[i] <= q_reg[i] * q_reg[i];
            end
            xy_reg <= q_reg[0] * q_reg[1];
            wz_reg <= q_reg[3] * q_reg[2];
            xz_reg <= q_reg[0] * q_reg[2];
            wy_reg <= q_reg[3] * q_reg[1];
            yz_reg <= q_reg[1] * q_reg[2];
            wx_reg <= q_reg[3] * q_reg[0];

            n_reg       <= PB'(sq_reg[0]) + PB'(sq_reg[1]) + PB'(sq_reg[2]) + PB'(sq_reg[3]);
            term_reg[0] <= PB'(sq_reg[1]) + PB'(sq_reg[2]);
            term_reg[1] <= PB'(xy_reg) - PB'(wz_reg);
            term_reg[2] <= PB'(xz_reg) + PB'(wy_reg);
            term_reg[3] <= PB'(xy_reg) + PB'(wz_reg);
            term_reg[4] <= PB'(sq_reg[0]) + PB'(sq_reg[2]);
            term_reg[5] <= PB'(yz_reg) - PB'(wx_reg);
            term_reg[6] <= PB'(xz_reg) - PB'(wy_reg);
            term_reg[7] <= PB'(yz_reg) + PB'(wx_reg);
            term_reg[8] <= PB'(sq_reg[0]) + PB'(sq_reg[1]);

            n_d_reg    <= n_reg;
            term_d_reg <= term_reg;
            d_reg      <= $signed({1'b0, bit_len(n_reg)}) - 7'sd31;
            zero_reg   <= (n_reg == '0);

            side_reg[0] <= side_next;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];

            work_reg <= work_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qsm_queue.sv -----
`default_nettype none
module qsm_queue (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  qsm_pkg::work_t   push_data,
    input  wire              pop,
    output qsm_pkg::work_t   head,
    output qsm_pkg::qstat_t  stat
);

    localparam int unsigned PW = qsm_pkg::QPTR;

    qsm_pkg::work_t  mem_reg [qsm_pkg::QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign stat.full  = (cnt_reg == (PW+1)'(qsm_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qsm_recip.sv -----
`default_nettype none
module qsm_recip (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           en,
    input  wire                           in_valid,
    input  qsm_pkg::work_t                in_work,
    output logic                          out_valid,
    output qsm_pkg::work_t                out_work,
    output logic [qsm_pkg::RBITS-1:0]     out_recip
);

    localparam int unsigned NS = qsm_pkg::DIV_STAGES;
    localparam int unsigned MB = qsm_pkg::MBITS;
    localparam int unsigned RB = qsm_pkg::RBITS;

    logic [NS-1:0]    vld_reg;
    logic [MB-1:0]    rem_reg  [NS];
    logic [RB-1:0]    quo_reg  [NS];
    qsm_pkg::work_t   work_reg [NS];
    logic [MB-1:0]    rem_prev [NS];
    logic [RB-1:0]    quo_prev [NS];
    logic [MB-1:0]    m_prev   [NS];
    logic [MB-1:0]    rem_next [NS];
    logic [RB-1:0]    quo_next [NS];

    assign out_valid = vld_reg[NS-1];
    assign out_work  = work_reg[NS-1];
    assign out_recip = quo_reg[NS-1];

    // restoring division of 2^61 by m, one quotient bit per stage
    always_comb begin
        logic [MB:0] t;
        logic        ge;
        rem_prev[0] = qsm_pkg::DIV_SEED;
        quo_prev[0] = '0;
        m_prev[0]   = in_work.m;
        for (int k = 1; k < NS; k++) begin
            rem_prev[k] = rem_reg[k-1];
            quo_prev[k] = quo_reg[k-1];
            m_prev[k]   = work_reg[k-1].m;
        end
        for (int k = 0; k < NS; k++) begin
            t  = {rem_prev[k], 1'b0};
            ge = (t >= {1'b0, m_prev[k]});
            rem_next[k] = ge ? MB'(t - {1'b0, m_prev[k]}) : MB'(t);
            quo_next[k] = {quo_prev[k][RB-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg[0] <= in_work;
            for (int k = 1; k < NS; k++) begin
                work_reg[k] <= work_reg[k-1];
            end
            for (int k = 0; k < NS; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qsm_back.sv -----
`default_nettype none
module qsm_back (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_valid,
    input  qsm_pkg::work_t    in_work,
    output logic              pop,
    output logic              out_valid,
    input  wire               out_ready,
    output logic [8:0][31:0]  out_mat,
    output logic [2:0][31:0]  out_trans
);

    localparam int unsigned VB = qsm_pkg::VBITS;
    localparam int unsigned SB = qsm_pkg::SBITS;
    localparam int unsigned RB = qsm_pkg::RBITS;
    localparam int unsigned NT = qsm_pkg::NTERMS;
    localparam logic signed [VB+15:0] SAT_HI = (VB+16)'(32'sh7fff_ffff);
    localparam logic signed [VB+15:0] SAT_LO = (VB+16)'(32'sh8000_0000);

    logic                     en;
    logic                     dv_valid;
    qsm_pkg::work_t           dv_work;
    logic [RB-1:0]            dv_recip;

    logic signed [SB+RB:0]    prod_next [NT];
    logic signed [VB-1:0]     v_next    [NT];
    logic                     vv_reg;
    logic signed [VB-1:0]     v_reg     [NT];
    logic                     zero_v_reg;
    qsm_pkg::side_t           side_v_reg;

    logic signed [VB-1:0]     rot_next  [NT];
    logic                     rv_reg;
    logic signed [VB-1:0]     rot_reg   [NT];
    qsm_pkg::side_t           side_r_reg;

    logic signed [VB+31:0]    sp_next   [NT];
    logic signed [VB+15:0]    sh_next   [NT];
    logic [8:0][31:0]         mat_next;
    logic                     ov_reg;
    logic [8:0][31:0]         mat_reg;
    logic [2:0][31:0]         trans_reg;

    assign en        = !ov_reg || out_ready;
    assign pop       = en && in_valid;
    assign out_valid = ov_reg;
    assign out_mat   = mat_reg;
    assign out_trans = trans_reg;

    qsm_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid),
        .in_work   (in_work),
        .out_valid (dv_valid),
        .out_work  (dv_work),
        .out_recip (dv_recip)
    );

    // 2p/n in q4.16
    always_comb begin
        for (int k = 0; k < NT; k++) begin
            prod_next[k] = $signed(dv_work.ps[k]) * $signed({1'b0, dv_recip});
            v_next[k]    = prod_next[k][VB+43:44];
        end
    end

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            if (qsm_pkg::DIAG_MASK[k]) begin
                rot_next[k] = zero_v_reg ? VB'(qsm_pkg::ONE_Q16)
                                         : VB'(qsm_pkg::ONE_Q16) - v_reg[k];
            end else begin
                rot_next[k] = zero_v_reg ? '0 : v_reg[k];
            end
        end
    end

    // column scale and saturation
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                sp_next[r*3+c] = rot_reg[r*3+c] * $signed(side_r_reg.scale[c]);
                sh_next[r*3+c] = sp_next[r*3+c][VB+31:16];
                if (sh_next[r*3+c] > SAT_HI) begin
                    mat_next[r*3+c] = 32'h7fff_ffff;
                end else if (sh_next[r*3+c] < SAT_LO) begin
                    mat_next[r*3+c] = 32'h8000_0000;
                end else begin
                    mat_next[r*3+c] = sh_next[r*3+c][31:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vv_reg <= 1'b0;
            rv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            vv_reg <= dv_valid;
            rv_reg <= vv_reg;
            ov_reg <= rv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg      <= v_next;
            zero_v_reg <= dv_work.zero;
            side_v_reg <= dv_work.side;
            rot_reg    <= rot_next;
            side_r_reg <= side_v_reg;
            mat_reg    <= mat_next;
            trans_reg  <= side_r_reg.pos;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/quaternion_scale_to_model_matrix_unit.sv -----
// channel  dir  width  fields (lowest bits first)
// s_       in   320    quat_x quat_y quat_z quat_w scale_x scale_y scale_z pos_x pos_y pos_z
// m_       out  384    m00 m01 m02 m10 m11 m12 m20 m21 m22 trans_x trans_y trans_z
//
// one transfer per cycle sustained while m_tready stays high
// the reciprocal divider is a 32-stage pipeline, one quotient bit per stage
// synchronous active-low reset clears valid flags, queue pointers and queue count only
// a four-entry queue splits the front pipeline from the divider and output side
// s_tready drops only while the queue is full and the front end holds an item
`default_nettype none
`include "quaternion_scale_to_model_matrix_unit_assert.svh"
module quaternion_scale_to_model_matrix_unit (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // quat_x quat_y quat_z quat_w scale_x scale_y scale_z pos_x pos_y pos_z
    input  wire [qsm_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22 trans_x trans_y trans_z
    output logic [qsm_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic [3:0][31:0]  quat;
    logic [2:0][31:0]  scale;
    logic [2:0][31:0]  pos;
    logic              push;
    logic              pop;
    qsm_pkg::work_t    push_data;
    qsm_pkg::work_t    head;
    qsm_pkg::qstat_t   qstat;
    logic [8:0][31:0]  mat;
    logic [2:0][31:0]  trans;

    assign quat    = s_tdata[127:0];
    assign scale   = s_tdata[223:128];
    assign pos     = s_tdata[319:224];
    assign m_tdata = {trans, mat};

    qsm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .quat      (quat),
        .scale     (scale),
        .pos       (pos),
        .q_full    (qstat.full),
        .push      (push),
        .push_data (push_data)
    );

    qsm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    qsm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (!qstat.empty),
        .in_work   (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mat   (mat),
        .out_trans (trans)
    );

    `QSM_ASSERT_IMPLIES(a_push_not_full, push, !qstat.full, "push into full queue")
    `QSM_ASSERT_IMPLIES(a_pop_not_empty, pop, !qstat.empty, "pop from empty queue")
    `QSM_ASSERT_IMPLIES(a_stall_full, !s_tready, qstat.full, "input stalled with room in queue")

endmodule
`default_nettype wire
